### sv/upm_pkg.sv
// shared types and constants of the pixel unpremultiply block
package upm_pkg;

    // channel count and default sample format
    localparam int NUM_CH            = 4;
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 12;

    // configuration port
    localparam int MASK_W      = 4;
    localparam int SEL_W       = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_DIVIDE_MASK    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIVISOR_SELECT = 1'd1;

    localparam logic [MASK_W-1:0] DIVIDE_MASK_RESET    = 4'd7;
    localparam logic [SEL_W-1:0]  DIVISOR_SELECT_RESET = 2'd3;

    // channel codes of divisor_select
    localparam logic [SEL_W-1:0] CH_RED   = 2'd0;
    localparam logic [SEL_W-1:0] CH_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [SEL_W-1:0] CH_ALPHA = 2'd3;

    // per-stage control that travels with each pixel
    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
        logic              div_zero;
        logic              div_neg;
    } upm_ctrl_t;

endpackage

### sv/upm_prep.sv
// input stage: divisor pick, magnitudes and signs
module upm_prep import upm_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  in_sample,
    input  logic [MASK_W-1:0]                    mask,
    input  logic [SEL_W-1:0]                     select,
    output upm_ctrl_t                            ctrl_reg,
    output logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  sample_reg,
    output logic [NUM_CH-1:0][SAMPLE_WIDTH+FRACTION_BITS-1:0] dvd_reg,
    output logic [SAMPLE_WIDTH-1:0]              dvs_reg
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = SAMPLE_WIDTH + FRACTION_BITS;

    logic [SW-1:0]                divisor;
    logic [SW-1:0]                dvs_next;
    logic [NUM_CH-1:0][DW-1:0]    dvd_next;
    upm_ctrl_t                    ctrl_next;

    // divisor channel taken from the incoming pixel
    always_comb begin
        unique case (select)
            CH_RED:   divisor = in_sample[0];
            CH_GREEN: divisor = in_sample[1];
            CH_BLUE:  divisor = in_sample[2];
            CH_ALPHA: divisor = in_sample[3];
        endcase
    end

    // magnitudes, dividend scaled by the fraction bits
    always_comb begin
        logic [SW-1:0] mag;
        dvs_next = divisor[SW-1] ? (~divisor + 1'b1) : divisor;
        for (int i = 0; i < NUM_CH; i++) begin
            mag = in_sample[i][SW-1] ? (~in_sample[i] + 1'b1) : in_sample[i];
            dvd_next[i] = {mag, {FRACTION_BITS{1'b0}}};
        end
        ctrl_next.valid    = in_valid;
        ctrl_next.mask     = mask;
        ctrl_next.div_zero = (divisor == '0);
        ctrl_next.div_neg  = divisor[SW-1];
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            sample_reg <= in_sample;
            dvd_reg    <= dvd_next;
            dvs_reg    <= dvs_next;
        end
    end

endmodule

### sv/upm_div_step.sv
// one restoring division step for all four channels, registered
module upm_div_step import upm_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  upm_ctrl_t                            ctrl_in,
    input  logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  sample_in,
    input  logic [SAMPLE_WIDTH-1:0]              dvs_in,
    input  logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  rem_in,
    input  logic [NUM_CH-1:0][SAMPLE_WIDTH+FRACTION_BITS-1:0] quot_in,
    output upm_ctrl_t                            ctrl_reg,
    output logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  sample_reg,
    output logic [SAMPLE_WIDTH-1:0]              dvs_reg,
    output logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  rem_reg,
    output logic [NUM_CH-1:0][SAMPLE_WIDTH+FRACTION_BITS-1:0] quot_reg
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = SAMPLE_WIDTH + FRACTION_BITS;

    logic [NUM_CH-1:0][SW-1:0] rem_next;
    logic [NUM_CH-1:0][DW-1:0] quot_next;

    // shift in the next dividend bit, subtract the divisor if it fits
    always_comb begin
        logic [SW:0]   trial;
        logic [SW-1:0] diff;
        for (int i = 0; i < NUM_CH; i++) begin
            trial = {rem_in[i], quot_in[i][DW-1]};
            // the difference is below the divisor whenever it is kept
            diff  = trial[SW-1:0] - dvs_in;
            if (trial >= {1'b0, dvs_in}) begin
                rem_next[i]  = diff;
                quot_next[i] = {quot_in[i][DW-2:0], 1'b1};
            end else begin
                rem_next[i]  = trial[SW-1:0];
                quot_next[i] = {quot_in[i][DW-2:0], 1'b0};
            end
        end
    end

    // control register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            sample_reg <= sample_in;
            dvs_reg    <= dvs_in;
            rem_reg    <= rem_next;
            quot_reg   <= quot_next;
        end
    end

endmodule

### sv/upm_post.sv
// output stage: sign, saturation, zero divisor and pass-through
module upm_post import upm_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  upm_ctrl_t                            ctrl_in,
    input  logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  sample_in,
    input  logic [NUM_CH-1:0][SAMPLE_WIDTH+FRACTION_BITS-1:0] quot_in,
    output logic                                 valid_reg,
    output logic [NUM_CH-1:0][SAMPLE_WIDTH-1:0]  result_reg,
    output logic                                 clip_reg
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = SAMPLE_WIDTH + FRACTION_BITS;

    localparam logic [DW-1:0] POS_LIMIT = {{(DW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic [DW-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;
    localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};

    logic [NUM_CH-1:0][SW-1:0] result_next;
    logic [NUM_CH-1:0]         clip_lane;

    // per channel result
    always_comb begin
        logic          neg;
        logic [SW-1:0] quot_low;
        for (int i = 0; i < NUM_CH; i++) begin
            neg          = sample_in[i][SW-1] ^ ctrl_in.div_neg;
            quot_low     = quot_in[i][SW-1:0];
            clip_lane[i] = 1'b0;
            priority if (!ctrl_in.mask[i]) begin
                result_next[i] = sample_in[i];
            end else if (ctrl_in.div_zero) begin
                result_next[i] = '0;
            end else if (neg) begin
                if (quot_in[i] > NEG_LIMIT) begin
                    result_next[i] = SAMPLE_MIN;
                    clip_lane[i]   = 1'b1;
                end else begin
                    result_next[i] = ~quot_low + 1'b1;
                end
            end else begin
                if (quot_in[i] > POS_LIMIT) begin
                    result_next[i] = SAMPLE_MAX;
                    clip_lane[i]   = 1'b1;
                end else begin
                    result_next[i] = quot_low;
                end
            end
        end
    end

    // valid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctrl_in.valid;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
            clip_reg   <= |clip_lane;
        end
    end

endmodule

### sv/upm_skid.sv
// output register with skid stage, keeps the pipeline enable registered
module upm_skid #(
    parameter int WIDTH = 65
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             in_ready,
    output logic             out_valid_reg,
    output logic [WIDTH-1:0] out_data_reg,
    input  logic             out_ready
);

    logic             skid_full_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             in_xfer;
    logic             out_load;

    assign in_ready = !skid_full_reg;
    assign in_xfer  = in_valid && !skid_full_reg;
    assign out_load = !out_valid_reg || out_ready;

    // control: output valid and skid occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= skid_full_reg || in_xfer;
            skid_full_reg <= 1'b0;
        end else if (in_xfer) begin
            skid_full_reg <= 1'b1;
        end
    end

    // data: output register drains the skid first
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= skid_full_reg ? skid_data_reg : in_data;
        end else if (in_xfer) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

### sv/pixel_unpremultiply.sv
// top level of the pixel unpremultiply block
//
// Divides the channels chosen by divide_mask of each RGBA pixel by the
// channel chosen by divisor_select, in signed fixed point, truncating toward
// zero; a zero divisor gives zero, out-of-range quotients saturate and set
// the clipped flag in m_tuser. Unselected channels pass through.
// Input pixels arrive on the s_ stream, results leave on the m_ stream,
// one result per pixel in order. Registers are written through the cfg_wr
// port, which the user must do only while the block holds no pixel; the
// block itself does not enforce this. Throughput: one pixel per cycle while
// the receiver takes results. The pipeline is an input stage, the restoring
// divider, which resolves one quotient bit per pipeline stage, a saturation
// stage and the output register.
// Reset empties the pipeline and loads divide_mask = 7, divisor_select = 3.
// When the receiver stalls, a skid stage catches the pixel in flight and the
// whole pipeline holds in the next cycle, with s_tready low, losing nothing.
module pixel_unpremultiply import upm_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int TDATA_W      = ((NUM_CH * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // red_in, green_in, blue_in, alpha_in from the lowest bit up, zero pad
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,
    // red_out, green_out, blue_out, alpha_out from the lowest bit up, zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,
    // clipped
    output logic [0:0]             m_tuser,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DW    = SAMPLE_WIDTH + FRACTION_BITS;
    localparam int PAY_W = NUM_CH * SW + 1;

    logic [MASK_W-1:0] divide_mask_reg;
    logic [SEL_W-1:0]  divisor_select_reg;

    logic                      en;
    logic [NUM_CH-1:0][SW-1:0] in_sample;

    upm_ctrl_t                 ctrl_s   [DW+1];
    logic [NUM_CH-1:0][SW-1:0] sample_s [DW+1];
    logic [SW-1:0]             dvs_s    [DW+1];
    logic [NUM_CH-1:0][SW-1:0] rem_s    [DW+1];
    logic [NUM_CH-1:0][DW-1:0] quot_s   [DW+1];

    logic                      post_valid;
    logic [NUM_CH-1:0][SW-1:0] post_result;
    logic                      post_clip;
    logic [PAY_W-1:0]          out_payload;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divide_mask_reg    <= DIVIDE_MASK_RESET;
            divisor_select_reg <= DIVISOR_SELECT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_DIVIDE_MASK:    divide_mask_reg    <= cfg_wr_data[MASK_W-1:0];
                REG_DIVISOR_SELECT: divisor_select_reg <= cfg_wr_data[SEL_W-1:0];
            endcase
        end
    end

    // unpack the input transfer
    assign in_sample = s_tdata[NUM_CH*SW-1:0];
    assign s_tready  = en;

    // input stage
    upm_prep #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_tvalid),
        .in_sample  (in_sample),
        .mask       (divide_mask_reg),
        .select     (divisor_select_reg),
        .ctrl_reg   (ctrl_s[0]),
        .sample_reg (sample_s[0]),
        .dvd_reg    (quot_s[0]),
        .dvs_reg    (dvs_s[0])
    );

    assign rem_s[0] = '0;

    // divider pipeline, one quotient bit per stage
    for (genvar k = 0; k < DW; k++) begin : g_step
        upm_div_step #(
            .SAMPLE_WIDTH  (SAMPLE_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_step (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .en         (en),
            .ctrl_in    (ctrl_s[k]),
            .sample_in  (sample_s[k]),
            .dvs_in     (dvs_s[k]),
            .rem_in     (rem_s[k]),
            .quot_in    (quot_s[k]),
            .ctrl_reg   (ctrl_s[k+1]),
            .sample_reg (sample_s[k+1]),
            .dvs_reg    (dvs_s[k+1]),
            .rem_reg    (rem_s[k+1]),
            .quot_reg   (quot_s[k+1])
        );
    end

    // sign, saturation and pass-through
    upm_post #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctrl_in    (ctrl_s[DW]),
        .sample_in  (sample_s[DW]),
        .quot_in    (quot_s[DW]),
        .valid_reg  (post_valid),
        .result_reg (post_result),
        .clip_reg   (post_clip)
    );

    // output register and skid stage
    upm_skid #(
        .WIDTH (PAY_W)
    ) u_skid (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (post_valid),
        .in_data       ({post_clip, post_result}),
        .in_ready      (en),
        .out_valid_reg (m_tvalid),
        .out_data_reg  (out_payload),
        .out_ready     (m_tready)
    );

    // pack the output transfer
    assign m_tdata = TDATA_W'(out_payload[NUM_CH*SW-1:0]);
    assign m_tuser = out_payload[PAY_W-1];

endmodule

### dv/tb_pixel_unpremultiply.sv
// self-checking testbench of the pixel unpremultiply block
`timescale 1ns / 1ps

module tb_pixel_unpremultiply;
    import upm_pkg::*;

    localparam int SW             = SAMPLE_WIDTH_DEF;
    localparam int FB             = FRACTION_BITS_DEF;
    localparam int TDATA_W        = ((NUM_CH * SW + 7) / 8) * 8;
    localparam int LATENCY        = SW + FB + 2;
    localparam int SAMPLE_MAX     = (1 << (SW - 1)) - 1;
    localparam int WATCHDOG_LIMIT = 5000;

    // one pixel, red in the lowest lane
    typedef logic [NUM_CH-1:0][SW-1:0] pixel_t;

    typedef struct packed {
        pixel_t pix;
        logic   clipped;
    } result_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata      = '0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;

    // copy of the register file as the block should hold it
    logic [MASK_W-1:0] cur_mask = DIVIDE_MASK_RESET;
    logic [SEL_W-1:0]  cur_sel  = DIVISOR_SELECT_RESET;

    result_t pending_results [$];
    result_t want;
    string   lane_name [NUM_CH] = '{"red_out", "green_out", "blue_out", "alpha_out"};

    int mismatches   = 0;
    int pixels_sent  = 0;
    int results_seen = 0;
    int clipped_seen = 0;
    int settings_cnt = 0;
    int idle_cycles  = 0;

    // idling controls of the sender and the receiver
    bit src_idle_on = 1'b1;
    bit snk_idle_on = 1'b1;
    int hold_req    = 0;
    int snk_count   = 0;

    pixel_unpremultiply uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pixel_t pack_px(input logic [SW-1:0] r, g, b, a);
        return {a, b, g, r};
    endfunction

    // expected result of one pixel under the current register values
    function automatic result_t unpremultiply(input pixel_t px);
        result_t res;
        longint  divisor;
        longint  quo;
        res.pix     = px;
        res.clipped = 1'b0;
        divisor     = longint'($signed(px[cur_sel]));
        for (int c = 0; c < NUM_CH; c++) begin
            if (cur_mask[c]) begin
                if (divisor == 0) begin
                    quo = 0;
                end else begin
                    quo = (longint'($signed(px[c])) * (longint'(1) << FB)) / divisor;
                    if (quo > SAMPLE_MAX) begin
                        quo = SAMPLE_MAX;
                        res.clipped = 1'b1;
                    end else if (quo < -SAMPLE_MAX - 1) begin
                        quo = -SAMPLE_MAX - 1;
                        res.clipped = 1'b1;
                    end
                end
                res.pix[c] = quo[SW-1:0];
            end
        end
        return res;
    endfunction

    // premultiplied-looking pixels, plus raw noise and corner values
    function automatic pixel_t random_pixel();
        pixel_t px;
        int     kind;
        int     d;
        int     v;
        kind = $urandom_range(0, 99);
        for (int c = 0; c < NUM_CH; c++)
            px[c] = SW'($urandom);
        if (kind < 45) begin
            d = $urandom_range(1, SAMPLE_MAX);
            for (int c = 0; c < NUM_CH; c++) begin
                if (c != cur_sel) begin
                    v = $urandom_range(0, d);
                    if ($urandom_range(0, 3) == 0)
                        v = -v;
                    px[c] = SW'(v);
                end
            end
            if ($urandom_range(0, 4) == 0)
                d = -d;
            px[cur_sel] = SW'(d);
        end else if (kind >= 70) begin
            for (int c = 0; c < NUM_CH; c++) begin
                case ($urandom_range(0, 7))
                    0: px[c] = '0;
                    1: px[c] = SW'(1);
                    2: px[c] = '1;
                    3: px[c] = SW'(SAMPLE_MAX);
                    4: px[c] = SW'(-SAMPLE_MAX - 1);
                    5: px[c] = SW'(1 << FB);
                    6: px[c] = SW'(-(1 << FB));
                    default: px[c] = SW'($urandom_range(0, 31)) - SW'(16);
                endcase
            end
        end
        return px;
    endfunction

    // offer one pixel and wait for its transfer
    task automatic send_pixel(input pixel_t px);
        int gap;
        gap = src_idle_on ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(px);
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), unpremultiply(px));
        pixels_sent++;
    endtask

    // stop offering and wait until every result has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DIVIDE_MASK)
            cur_mask = data[MASK_W-1:0];
        else
            cur_sel = data[SEL_W-1:0];
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [MASK_W-1:0] mask, input logic [SEL_W-1:0] sel);
        wait_idle();
        cfg_write(REG_DIVIDE_MASK, CFG_DATA_W'(mask));
        cfg_write(REG_DIVISOR_SELECT, CFG_DATA_W'(sel));
        settings_cnt++;
    endtask

    // reset values: red, green, blue divided by alpha
    task automatic test_reset_defaults();
        send_pixel(pack_px(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_pixel(pack_px(16'h7fff, 16'h8000, 16'h0001, 16'h1000));
        send_pixel(pack_px(16'h7fff, 16'h8000, 16'h0000, 16'h0001));
        send_pixel(pack_px(16'h0008, 16'hfff8, 16'h0007, 16'hffff));
        send_pixel(pack_px(16'h8000, 16'h7fff, 16'h0001, 16'h8000));
        send_pixel(pack_px(16'h7fff, 16'h8000, 16'hfffb, 16'h7fff));
        send_pixel(pack_px(16'hfffb, 16'h0005, 16'h0002, 16'h0003));
        send_pixel(pack_px(16'h0400, 16'h0200, 16'hfc00, 16'h0800));
    endtask

    // self division, empty mask, every divisor channel, zero divisors
    task automatic test_special_cases();
        apply_settings(4'hf, CH_ALPHA);
        send_pixel(pack_px(16'h0800, 16'h0100, 16'h0000, 16'h1234));
        send_pixel(pack_px(16'h0800, 16'h0100, 16'h7fff, 16'h0000));
        send_pixel(pack_px(16'h4000, 16'hc000, 16'h0001, 16'h8000));
        apply_settings(4'h0, CH_ALPHA);
        send_pixel(pack_px(16'h7fff, 16'h8000, 16'h0000, 16'h0001));
        send_pixel(pack_px(16'h1234, 16'hedcb, 16'h0fff, 16'h0000));
        apply_settings(4'hf, CH_RED);
        send_pixel(pack_px(16'h1000, 16'h0800, 16'hf000, 16'h7fff));
        send_pixel(pack_px(16'h0000, 16'h0800, 16'hf000, 16'h7fff));
        apply_settings(4'hf, CH_GREEN);
        send_pixel(pack_px(16'h0010, 16'hffff, 16'h8000, 16'h0001));
        send_pixel(pack_px(16'h0010, 16'h0000, 16'h8000, 16'h0001));
        apply_settings(4'h5, CH_BLUE);
        send_pixel(pack_px(16'h0400, 16'h1111, 16'h0800, 16'h2222));
        send_pixel(pack_px(16'h7fff, 16'h3333, 16'h8000, 16'h4444));
    endtask

    // random pixels across a series of register settings, extremes first
    task automatic test_random_settings();
        logic [MASK_W-1:0] mask;
        logic [SEL_W-1:0]  sel;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin mask = 4'h0; sel = CH_RED;   end
                1: begin mask = 4'hf; sel = CH_ALPHA; end
                2: begin mask = 4'hf; sel = CH_RED;   end
                3: begin mask = 4'h7; sel = CH_ALPHA; end
                default: begin
                    mask = MASK_W'($urandom);
                    sel  = SEL_W'($urandom);
                end
            endcase
            apply_settings(mask, sel);
            // every fourth phase runs without any idling
            src_idle_on = (ph % 4 != 1);
            snk_idle_on = (ph % 4 != 1);
            repeat (140) send_pixel(random_pixel());
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        apply_settings(4'hb, CH_ALPHA);
        src_idle_on = 1'b0;
        hold_req    = 300;
        repeat (150) send_pixel(random_pixel());
        src_idle_on = 1'b1;
    endtask

    // short bursts, each drained fully before the next
    task automatic test_bursts_with_drain();
        for (int n = 0; n < 4; n++) begin
            apply_settings(MASK_W'($urandom), SEL_W'($urandom));
            repeat (20) send_pixel(random_pixel());
            wait_idle();
        end
    endtask

    // receiver: random ready pattern, or a long hold when asked for one
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_count = 0;
        end else if (hold_req != 0) begin
            m_tready <= 1'b0;
            snk_count = hold_req;
            hold_req  = 0;
        end else if (snk_count > 0) begin
            snk_count--;
        end else if (snk_idle_on && $urandom_range(0, 2) == 0) begin
            m_tready <= 1'b0;
            snk_count = idle_len();
        end else begin
            m_tready <= 1'b1;
            snk_count = $urandom_range(0, 7);
        end
    end

    // compare each result transfer with the oldest expected pixel
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected, got %h / %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (want.clipped)
                    clipped_seen++;
                for (int c = 0; c < NUM_CH; c++) begin
                    if (m_tdata[c*SW +: SW] !== want.pix[c]) begin
                        $display("%0t: %s mismatch, expected %h, got %h",
                                 $time, lane_name[c], want.pix[c], m_tdata[c*SW +: SW]);
                        mismatches++;
                    end
                end
                if (m_tuser[0] !== want.clipped) begin
                    $display("%0t: clipped mismatch, expected %b, got %b",
                             $time, want.clipped, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_special_cases();
        test_random_settings();
        test_backpressure();
        test_bursts_with_drain();

        wait_idle();
        repeat (LATENCY + 10) @(posedge aclk);

        $display("run covered %0d pixels and %0d result transfers, %0d of them clipped,",
                 pixels_sent, results_seen, clipped_seen);
        $display("over %0d register settings, with random stalls and a long receiver hold",
                 settings_cnt);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
sv/upm_pkg.sv
sv/upm_prep.sv
sv/upm_div_step.sv
sv/upm_post.sv
sv/upm_skid.sv
sv/pixel_unpremultiply.sv
dv/tb_pixel_unpremultiply.sv
